>>> rtl/svc_pkg.sv
// ----------------------------------------------------------------------------
// svc_pkg: shared definitions of the scalar/vector core
// Sizes, instruction codes, item classes and the queue item type.
// ----------------------------------------------------------------------------
package svc_pkg;

  localparam int MEM_BYTES    = 65536;
  localparam int VECTOR_BYTES = 128;
  localparam int NUM_VREGS    = 32;
  localparam int NUM_SREGS    = 32;

  localparam int MEM_ROWS   = MEM_BYTES / 4;
  localparam int ROW_BITS   = $clog2(MEM_ROWS);
  localparam int ADDR_BITS  = ROW_BITS + 2;
  localparam int VEC_WORDS  = VECTOR_BYTES / 4;
  localparam int VW_BITS    = $clog2(VEC_WORDS);
  localparam int VREG_WORDS = NUM_VREGS * VEC_WORDS;
  localparam int VA_BITS    = $clog2(VREG_WORDS);
  localparam int CLR_ROWS   = (MEM_ROWS > VREG_WORDS) ? MEM_ROWS : VREG_WORDS;
  localparam int CLR_BITS   = $clog2(CLR_ROWS + 1);

  localparam logic [31:0] WORD_LIMIT = 32'(MEM_BYTES - 4);
  localparam logic [31:0] VEC_LIMIT  = 32'(MEM_BYTES - VECTOR_BYTES);

  localparam int QDEPTH  = 2;
  localparam int QP_BITS = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    MODE_STEP  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_START = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STOP   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    KIND_STEP,
    KIND_WRITE,
    KIND_READ,
    KIND_START,
    KIND_REJECT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FETCH,
    S_EXEC,
    S_LOAD,
    S_VEC,
    S_REPLY
  } back_state_t;

  localparam logic [3:0] CLS_ALU   = 4'd1;
  localparam logic [3:0] CLS_LOAD  = 4'd2;
  localparam logic [3:0] CLS_STORE = 4'd3;
  localparam logic [3:0] CLS_BR    = 4'd4;
  localparam logic [3:0] CLS_CMP   = 4'd5;
  localparam logic [3:0] CLS_MOVI  = 4'd6;
  localparam logic [3:0] CLS_VOP   = 4'd7;
  localparam logic [3:0] CLS_VLD   = 4'd8;
  localparam logic [3:0] CLS_VST   = 4'd9;
  localparam logic [3:0] CLS_HALT  = 4'd15;

  localparam logic [3:0] ALU_ADD = 4'd0;
  localparam logic [3:0] ALU_SUB = 4'd1;
  localparam logic [3:0] ALU_AND = 4'd2;
  localparam logic [3:0] ALU_OR  = 4'd3;
  localparam logic [3:0] ALU_XOR = 4'd4;
  localparam logic [3:0] ALU_SHL = 4'd5;
  localparam logic [3:0] ALU_SHR = 4'd6;
  localparam logic [3:0] ALU_MUL = 4'd7;

  localparam logic [3:0] CMP_EQ = 4'd0;
  localparam logic [3:0] CMP_GT = 4'd1;
  localparam logic [3:0] CMP_LT = 4'd2;
  localparam logic [3:0] CMP_NE = 4'd3;

  localparam logic [1:0] ELEM_BYTE = 2'd0;
  localparam logic [1:0] ELEM_HALF = 2'd1;
  localparam logic [1:0] ELEM_NONE = 2'd3;

  localparam logic [1:0] VOP_ADD  = 2'd0;
  localparam logic [1:0] VOP_MUL  = 2'd1;
  localparam logic [1:0] VOP_NONE = 2'd3;

endpackage

>>> rtl/svc_front.sv
// ----------------------------------------------------------------------------
// svc_front: item intake
// Accepts items and classifies them by mode and address range for the queue.
// ----------------------------------------------------------------------------
module svc_front import svc_pkg::*; (
  input  logic        start,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  input  q_status_t   qs,
  input  logic        clearing,
  output logic        busy,
  output logic        push,
  output item_t       push_item
);

  logic addr_ok;

  assign addr_ok = (address <= WORD_LIMIT);
  assign busy    = qs.full | clearing;
  assign push    = start & ~busy;

  always_comb begin
    push_item.addr = address;
    push_item.data = write_data;
    case (mode_t'(mode))
      MODE_STEP:  push_item.kind = KIND_STEP;
      MODE_WRITE: push_item.kind = addr_ok ? KIND_WRITE : KIND_REJECT;
      MODE_READ:  push_item.kind = addr_ok ? KIND_READ : KIND_REJECT;
      MODE_START: push_item.kind = KIND_START;
      default:    push_item.kind = KIND_REJECT;
    endcase
  end

endmodule

>>> rtl/svc_queue.sv
// ----------------------------------------------------------------------------
// svc_queue: item queue
// A short first-in first-out queue between the intake and the executor.
// ----------------------------------------------------------------------------
module svc_queue import svc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head,
  output q_status_t qs
);

  item_t                slots [QDEPTH];
  logic [QP_BITS-1:0]   wp;
  logic [QP_BITS-1:0]   rp;
  logic [QP_BITS:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign qs.full  = (count == (QP_BITS+1)'(QDEPTH));
  assign qs.empty = (count == '0);
  assign head     = slots[rp];
  assign do_push  = push & ~qs.full;
  assign do_pop   = pop & ~qs.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 1'b1;
      end
      if (do_pop) begin
        rp <= rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/svc_back.sv
// ----------------------------------------------------------------------------
// svc_back: executor
// Holds memory, scalar, predicate and vector state and carries out items.
// ----------------------------------------------------------------------------
module svc_back import svc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  item_t       head,
  input  q_status_t   qs,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] read_data,
  output logic [31:0] program_counter_out,
  output logic        running_out,
  output logic [31:0] cycle_count_out
);

  // Lane arithmetic on one 32-bit word of a vector.
  function automatic logic [31:0] lane_op(logic [1:0] op, logic [1:0] ec,
                                          logic [31:0] x, logic [31:0] y);
    logic [31:0] r8;
    logic [31:0] r16;
    logic [31:0] r32;
    for (int k = 0; k < 4; k++) begin
      case (op)
        VOP_ADD: r8[8*k +: 8] = x[8*k +: 8] + y[8*k +: 8];
        VOP_MUL: r8[8*k +: 8] = x[8*k +: 8] * y[8*k +: 8];
        default: r8[8*k +: 8] = x[8*k +: 8] - y[8*k +: 8];
      endcase
    end
    for (int k = 0; k < 2; k++) begin
      case (op)
        VOP_ADD: r16[16*k +: 16] = x[16*k +: 16] + y[16*k +: 16];
        VOP_MUL: r16[16*k +: 16] = x[16*k +: 16] * y[16*k +: 16];
        default: r16[16*k +: 16] = x[16*k +: 16] - y[16*k +: 16];
      endcase
    end
    case (op)
      VOP_ADD: r32 = x + y;
      VOP_MUL: r32 = x * y;
      default: r32 = x - y;
    endcase
    case (ec)
      ELEM_BYTE: return r8;
      ELEM_HALF: return r16;
      default:   return r32;
    endcase
  endfunction

  back_state_t          state;
  back_state_t          state_next;
  logic [31:0]          insn;
  logic [31:0]          insn_next;
  logic [31:0]          pc;
  logic [31:0]          pc_next;
  logic                 running;
  logic                 running_next;
  logic [31:0]          cycles;
  logic [31:0]          cycles_next;
  logic [3:0]           preds;
  logic [3:0]           preds_next;
  status_t              status_q;
  status_t              status_q_next;
  logic [31:0]          rdata_q;
  logic [31:0]          rdata_q_next;
  logic [CLR_BITS-1:0]  clr;
  logic [CLR_BITS-1:0]  clr_next;
  logic [VW_BITS:0]     beat;
  logic [VW_BITS:0]     beat_next;
  logic                 pend_v;
  logic                 pend_v_next;
  logic [VW_BITS-1:0]   pend_idx;
  logic [VW_BITS-1:0]   pend_idx_next;
  logic [ADDR_BITS-1:0] vbase;
  logic [ADDR_BITS-1:0] vbase_next;

  // Data memory port, four byte banks.
  logic                 m_we;
  logic [ADDR_BITS-1:0] m_addr;
  logic [31:0]          m_wdata;
  logic [7:0]           ram [4][MEM_ROWS];
  logic [ROW_BITS-1:0]  bank_row [4];
  logic [7:0]           bank_wb [4];
  logic [3:0]           bank_we;
  logic [7:0]           bank_q [4];
  logic [1:0]           off_q;
  logic [31:0]          mem_word;

  // Scalar register file.
  logic [31:0]          sram [NUM_SREGS];
  logic                 sw_en;
  logic [4:0]           sw_addr;
  logic [31:0]          sw_data;
  logic [4:0]           sr_a_addr;
  logic [4:0]           sr_b_addr;
  logic [31:0]          sq_a;
  logic [31:0]          sq_b;

  // Vector register file, one word per entry.
  logic [31:0]          vram [VREG_WORDS];
  logic                 vw_en;
  logic [VA_BITS-1:0]   vw_addr;
  logic [31:0]          vw_data;
  logic [VA_BITS-1:0]   vr_a_addr;
  logic [VA_BITS-1:0]   vr_b_addr;
  logic [31:0]          vq_a;
  logic [31:0]          vq_b;

  // Instruction fields.
  logic [3:0]           cls;
  logic [3:0]           sub;
  logic [4:0]           f_rd;
  logic [4:0]           f_rs;
  logic [4:0]           f_rt;
  logic [31:0]          simm;
  logic [33:0]          ea;
  logic                 ea_bad;
  logic [31:0]          alu_r;

  assign cls      = insn[31:28];
  assign sub      = insn[27:24];
  assign f_rd     = insn[23:19];
  assign f_rs     = insn[18:14];
  assign f_rt     = insn[13:9];
  assign simm     = {{23{insn[8]}}, insn[8:0]};
  assign ea       = {2'b00, sq_a} + {{2{simm[31]}}, simm};
  assign ea_bad   = ea[33] | (ea[32:0] > {1'b0, WORD_LIMIT});
  assign clearing = (state == S_CLEAR);

  always_comb begin
    case (sub)
      ALU_ADD: alu_r = sq_a + sq_b;
      ALU_SUB: alu_r = sq_a - sq_b;
      ALU_AND: alu_r = sq_a & sq_b;
      ALU_OR:  alu_r = sq_a | sq_b;
      ALU_XOR: alu_r = sq_a ^ sq_b;
      ALU_SHL: alu_r = sq_a << sq_b[4:0];
      ALU_SHR: alu_r = sq_a >> sq_b[4:0];
      ALU_MUL: alu_r = sq_a * sq_b;
      default: alu_r = '0;
    endcase
  end

  // Bank addressing: byte j of an unaligned word lives in bank (addr + j) mod 4.
  always_comb begin
    logic [1:0]           off;
    logic [ADDR_BITS-1:0] baddr;
    for (int k = 0; k < 4; k++) begin
      off   = 2'(k) - m_addr[1:0];
      baddr = m_addr + ADDR_BITS'(off);
      if (clearing) begin
        bank_row[k] = clr[ROW_BITS-1:0];
        bank_we[k]  = (clr < CLR_BITS'(MEM_ROWS));
        bank_wb[k]  = '0;
      end else begin
        bank_row[k] = baddr[ADDR_BITS-1:2];
        bank_we[k]  = m_we;
        bank_wb[k]  = m_wdata[8*off +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (bank_we[k]) begin
        ram[k][bank_row[k]] <= bank_wb[k];
      end
      bank_q[k] <= ram[k][bank_row[k]];
    end
    off_q <= m_addr[1:0];
  end

  always_comb begin
    logic [1:0] idx;
    for (int j = 0; j < 4; j++) begin
      idx = off_q + 2'(j);
      mem_word[8*j +: 8] = bank_q[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      sram[sw_addr] <= sw_data;
    end
    sq_a <= sram[sr_a_addr];
    sq_b <= sram[sr_b_addr];
  end

  always_ff @(posedge clk) begin
    if (vw_en) begin
      vram[vw_addr] <= vw_data;
    end
    vq_a <= vram[vr_a_addr];
    vq_b <= vram[vr_b_addr];
  end

  always_comb begin
    state_next    = state;
    insn_next     = insn;
    pc_next       = pc;
    running_next  = running;
    cycles_next   = cycles;
    preds_next    = preds;
    status_q_next = status_q;
    rdata_q_next  = rdata_q;
    clr_next      = clr;
    beat_next     = beat;
    pend_v_next   = 1'b0;
    pend_idx_next = pend_idx;
    vbase_next    = vbase;
    pop           = 1'b0;
    m_we          = 1'b0;
    m_addr        = head.addr[ADDR_BITS-1:0];
    m_wdata       = head.data;
    sw_en         = 1'b0;
    sw_addr       = f_rd;
    sw_data       = alu_r;
    sr_a_addr     = mem_word[18:14];
    sr_b_addr     = mem_word[13:9];
    vw_en         = 1'b0;
    vw_addr       = {f_rd, pend_idx};
    vw_data       = mem_word;
    vr_a_addr     = {f_rs, beat[VW_BITS-1:0]};
    vr_b_addr     = {f_rt, beat[VW_BITS-1:0]};

    case (state)
      S_CLEAR: begin
        sw_en    = (clr < CLR_BITS'(NUM_SREGS));
        sw_addr  = clr[4:0];
        sw_data  = '0;
        vw_en    = (clr < CLR_BITS'(VREG_WORDS));
        vw_addr  = clr[VA_BITS-1:0];
        vw_data  = '0;
        clr_next = clr + 1'b1;
        if (clr == CLR_BITS'(CLR_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!qs.empty) begin
          pop          = 1'b1;
          rdata_q_next = '0;
          status_q_next = ST_OK;
          state_next   = S_REPLY;
          case (head.kind)
            KIND_WRITE: begin
              m_we = 1'b1;
            end
            KIND_READ: begin
              state_next = S_READ;
            end
            KIND_START: begin
              pc_next      = head.addr;
              running_next = 1'b1;
            end
            KIND_STEP: begin
              if (!running) begin
                status_q_next = ST_REJECT;
              end else if (pc > WORD_LIMIT) begin
                running_next  = 1'b0;
                status_q_next = ST_STOP;
              end else begin
                m_addr     = pc[ADDR_BITS-1:0];
                state_next = S_FETCH;
              end
            end
            default: begin
              status_q_next = ST_REJECT;
            end
          endcase
        end
      end

      S_READ: begin
        rdata_q_next = mem_word;
        state_next   = S_REPLY;
      end

      S_FETCH: begin
        insn_next  = mem_word;
        state_next = S_EXEC;
      end

      S_EXEC: begin
        pc_next     = pc + 32'd4;
        cycles_next = cycles + 32'd1;
        state_next  = S_REPLY;
        case (cls)
          CLS_ALU: begin
            sw_en = (f_rd != '0);
          end
          CLS_LOAD, CLS_STORE: begin
            if (ea_bad) begin
              running_next  = 1'b0;
              status_q_next = ST_STOP;
              sw_en         = (cls == CLS_LOAD) && (f_rd != '0);
              sw_data       = '0;
            end else if (cls == CLS_LOAD) begin
              m_addr     = ea[ADDR_BITS-1:0];
              state_next = S_LOAD;
            end else begin
              m_we    = 1'b1;
              m_addr  = ea[ADDR_BITS-1:0];
              m_wdata = sq_b;
            end
          end
          CLS_BR: begin
            if (preds[f_rd[1:0]]) begin
              pc_next = pc + simm;
            end
          end
          CLS_CMP: begin
            case (sub)
              CMP_EQ:  preds_next[f_rd[1:0]] = (sq_a == sq_b);
              CMP_GT:  preds_next[f_rd[1:0]] = (sq_a > sq_b);
              CMP_LT:  preds_next[f_rd[1:0]] = (sq_a < sq_b);
              CMP_NE:  preds_next[f_rd[1:0]] = (sq_a != sq_b);
              default: preds_next = preds;
            endcase
          end
          CLS_MOVI: begin
            sw_en   = (f_rd != '0);
            sw_data = {16'd0, insn[15:0]};
          end
          CLS_VOP: begin
            cycles_next = cycles + 32'd2;
            beat_next   = '0;
            if (sub[1:0] != ELEM_NONE && sub[3:2] != VOP_NONE) begin
              state_next = S_VEC;
            end
          end
          CLS_VLD, CLS_VST: begin
            cycles_next = cycles + 32'd2;
            beat_next   = '0;
            vbase_next  = sq_a[ADDR_BITS-1:0];
            if (sq_a <= VEC_LIMIT) begin
              state_next = S_VEC;
            end
          end
          CLS_HALT: begin
            running_next  = 1'b0;
            status_q_next = ST_STOP;
          end
          default: begin
            state_next = S_REPLY;
          end
        endcase
      end

      S_LOAD: begin
        sw_en      = (f_rd != '0);
        sw_data    = mem_word;
        state_next = S_REPLY;
      end

      S_VEC: begin
        // Issue side: one word of the vector per cycle.
        if (beat < (VW_BITS+1)'(VEC_WORDS)) begin
          beat_next     = beat + 1'b1;
          pend_v_next   = 1'b1;
          pend_idx_next = beat[VW_BITS-1:0];
          m_addr        = vbase + ADDR_BITS'({beat[VW_BITS-1:0], 2'b00});
          if (cls == CLS_VST) begin
            vr_a_addr = {f_rd, beat[VW_BITS-1:0]};
          end
        end
        // Completion side: the word read in the previous cycle is written.
        if (pend_v) begin
          case (cls)
            CLS_VOP: begin
              vw_en   = 1'b1;
              vw_data = lane_op(sub[3:2], sub[1:0], vq_a, vq_b);
            end
            CLS_VLD: begin
              vw_en = 1'b1;
            end
            default: begin
              m_we    = 1'b1;
              m_addr  = vbase + ADDR_BITS'({pend_idx, 2'b00});
              m_wdata = vq_a;
            end
          endcase
        end else if (beat == (VW_BITS+1)'(VEC_WORDS)) begin
          state_next = S_REPLY;
        end
      end

      S_REPLY: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    insn     <= insn_next;
    status_q <= status_q_next;
    rdata_q  <= rdata_q_next;
    pend_idx <= pend_idx_next;
    vbase    <= vbase_next;
    if (state == S_REPLY) begin
      status              <= status_q;
      read_data           <= rdata_q;
      program_counter_out <= pc;
      running_out         <= running;
      cycle_count_out     <= cycles;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      pc      <= '0;
      running <= 1'b0;
      cycles  <= '0;
      preds   <= '0;
      clr     <= '0;
      beat    <= '0;
      pend_v  <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      pc      <= pc_next;
      running <= running_next;
      cycles  <= cycles_next;
      preds   <= preds_next;
      clr     <= clr_next;
      beat    <= beat_next;
      pend_v  <= pend_v_next;
      done    <= (state == S_REPLY);
    end
  end

endmodule

>>> rtl/scalar_vector_core_step_core.sv
// ----------------------------------------------------------------------------
// scalar_vector_core_step_core: small scalar/vector core, one item at a time
// Intake, a short item queue and an executor holding all architectural state.
// ----------------------------------------------------------------------------
// Usage. An item (mode, address, write_data) is taken at a rising edge where
// start is high and busy is low. An item either executes one instruction,
// writes or reads a little-endian word of data memory, or starts the core at
// an address. Each item yields exactly one result, presented for a single
// cycle with done high: status, read_data, and the program counter, running
// flag and cycle counter as they stand after the item.
// The intake classifies the item and places it in a two-entry queue, so a new
// item can be taken while the executor is still at work; busy rises only when
// the queue is full or the clearing pass runs.
// Writes, starts and rejected items go from the queue straight to the reply;
// reads pass through a memory read state, a scalar instruction through fetch
// and execute, and a scalar load through a further load state. Vector
// instructions stream one 32-bit word per cycle through the memory or vector
// register file port; a skipped vector access or a vector no-op goes from
// execute straight to the reply. The instruction fetch, the register file
// read and the single data memory port set this sequence of states.
// After reset the core runs a clearing pass over the memories, one row per
// cycle over CLR_ROWS rows (16384 at the default size), holding busy high.
// The receiver cannot stall: a result is valid only in its done cycle.
// ----------------------------------------------------------------------------
module scalar_vector_core_step_core import svc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  input  logic [31:0] write_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] read_data,
  output logic [31:0] program_counter_out,
  output logic        running_out,
  output logic [31:0] cycle_count_out
);

  q_status_t qs;
  item_t     push_item;
  item_t     head;
  logic      push;
  logic      pop;
  logic      clearing;

  // Intake: classification of the mode and the word address range.
  svc_front u_front (
    .start      (start),
    .mode       (mode),
    .address    (address),
    .write_data (write_data),
    .qs         (qs),
    .clearing   (clearing),
    .busy       (busy),
    .push       (push),
    .push_item  (push_item)
  );

  // The queue lets intake and execution stall independently.
  svc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  // Executor: memories, register files and the instruction sequencer.
  svc_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head                (head),
    .qs                  (qs),
    .pop                 (pop),
    .clearing            (clearing),
    .done                (done),
    .status              (status),
    .read_data           (read_data),
    .program_counter_out (program_counter_out),
    .running_out         (running_out),
    .cycle_count_out     (cycle_count_out)
  );

endmodule
